// ----- rtl/egcd_pkg.sv -----
// Package for the extended GCD block: operand and coefficient widths, types, the
// status struct shared by the core and the top level, and the step-result struct
// shared by the core and the step unit. No dependencies.
`timescale 1ns / 1ps

package egcd_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int COEF_BITS    = OPERAND_BITS + 1;
  localparam int CNT_BITS     = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0]       operand_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic [CNT_BITS-1:0]           cnt_t;

  localparam coef_t COEF_ZERO = COEF_BITS'(0);
  localparam coef_t COEF_ONE  = COEF_BITS'(1);

  typedef struct packed {
    logic busy;
    logic done;
  } core_status_t;

  typedef struct packed {
    logic     ge;
    operand_t diff;
    coef_t    xa;
    coef_t    xb;
  } step_res_t;

endpackage

// ----- rtl/egcd_step_unit.sv -----
// Shared compare/subtract unit: remainder minus shifted divisor, and both
// coefficient accumulators minus the current coefficients shifted by cnt.
// Depends on egcd_pkg.
`timescale 1ns / 1ps

module egcd_step_unit (
  input  egcd_pkg::operand_t  rem,
  input  egcd_pkg::operand_t  sub_op,
  input  egcd_pkg::coef_t     acc_a,
  input  egcd_pkg::coef_t     acc_b,
  input  egcd_pkg::coef_t     cur_a,
  input  egcd_pkg::coef_t     cur_b,
  input  egcd_pkg::cnt_t      cnt,
  output egcd_pkg::step_res_t res
);
  import egcd_pkg::*;

  logic [OPERAND_BITS:0] diff_w;

  assign diff_w   = {1'b0, rem} - {1'b0, sub_op};
  assign res.ge   = ~diff_w[OPERAND_BITS];
  assign res.diff = diff_w[OPERAND_BITS-1:0];
  // modulo 2^COEF_BITS; final coefficients fit, so wraparound is exact
  assign res.xa   = acc_a - (cur_a << cnt);
  assign res.xb   = acc_b - (cur_b << cnt);

endmodule

// ----- rtl/egcd_core.sv -----
// Sequencer and working registers of the extended Euclid iteration; each
// quotient is formed by shift-subtract through egcd_step_unit.
// Depends on egcd_pkg, egcd_step_unit.
`timescale 1ns / 1ps

module egcd_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   ack,
  input  egcd_pkg::operand_t     value_a,
  input  egcd_pkg::operand_t     value_b,
  output egcd_pkg::core_status_t status,
  output egcd_pkg::coef_t        coef_a,
  output egcd_pkg::coef_t        coef_b,
  output egcd_pkg::operand_t     divisor
);
  import egcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUB,
    ST_DONE
  } state_t;

  state_t    state;
  operand_t  rp, rc, rem, d;
  coef_t     xap, xac, xbp, xbc, acc_a, acc_b;
  cnt_t      cnt;

  operand_t  sub_op;
  step_res_t st;
  operand_t  rem_next;
  coef_t     acc_a_next, acc_b_next;

  // align phase tests the doubled divisor, subtract phase the divisor itself
  assign sub_op = (state == ST_ALIGN) ? {d[OPERAND_BITS-2:0], 1'b0} : d;

  egcd_step_unit u_step (
    .rem    (rem),
    .sub_op (sub_op),
    .acc_a  (acc_a),
    .acc_b  (acc_b),
    .cur_a  (xac),
    .cur_b  (xbc),
    .cnt    (cnt),
    .res    (st)
  );

  assign rem_next   = st.ge ? st.diff : rem;
  assign acc_a_next = st.ge ? st.xa   : acc_a;
  assign acc_b_next = st.ge ? st.xb   : acc_b;

  assign status.busy = (state != ST_IDLE);
  assign status.done = (state == ST_DONE);
  assign coef_a      = xap;
  assign coef_b      = xbp;
  assign divisor     = rp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rp    <= value_a;
            rc    <= value_b;
            xap   <= COEF_ONE;
            xac   <= COEF_ZERO;
            xbp   <= COEF_ZERO;
            xbc   <= COEF_ONE;
            rem   <= value_a;
            d     <= value_b;
            cnt   <= '0;
            acc_a <= COEF_ONE;
            acc_b <= COEF_ZERO;
            state <= (value_b == '0) ? ST_DONE : ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          if (!d[OPERAND_BITS-1] && st.ge) begin
            d   <= {d[OPERAND_BITS-2:0], 1'b0};
            cnt <= cnt + 1'b1;
          end else begin
            state <= ST_SUB;
          end
        end
        ST_SUB: begin
          if (cnt == '0) begin
            // quotient complete: rotate the remainder and coefficient pairs
            rp  <= rc;
            rc  <= rem_next;
            xap <= xac;
            xac <= acc_a_next;
            xbp <= xbc;
            xbc <= acc_b_next;
            if (rem_next == '0) begin
              state <= ST_DONE;
            end else begin
              rem   <= rc;
              d     <= rem_next;
              acc_a <= xac;
              acc_b <= xbc;
              state <= ST_ALIGN;
            end
          end else begin
            rem   <= rem_next;
            acc_a <= acc_a_next;
            acc_b <= acc_b_next;
            d     <= {1'b0, d[OPERAND_BITS-1:1]};
            cnt   <= cnt - 1'b1;
          end
        end
        ST_DONE: begin
          if (ack) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/extended_gcd.sv -----
// Top level of the extended GCD block: operand handshake, iterative core,
// and the result register that parts the core from the result channel.
// Depends on egcd_pkg, egcd_core.
//
//   channel  direction  handshake             payload
//   op       in         op_valid / op_stall   value_a, value_b
//   res      out        res_valid / res_stall coef_a, coef_b, divisor
//
// Each operand pair is taken in, then each Euclid step runs an align phase that
// doubles the divisor while the doubled divisor does not exceed the remainder,
// then a subtract phase; the shared compare/subtract unit handles one quotient bit per cycle
// (align, then subtract). Operand b of zero goes straight to done.
// op_stall is high whenever the core is not idle, also while it holds a finished result.
// A new pair is taken while the previous result still waits in the result register.
// Synchronous reset clears the sequencer and res_valid.
`timescale 1ns / 1ps

module extended_gcd (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  output logic                op_stall,
  input  egcd_pkg::operand_t  value_a,
  input  egcd_pkg::operand_t  value_b,
  output logic                res_valid,
  input  logic                res_stall,
  output egcd_pkg::coef_t     coef_a,
  output egcd_pkg::coef_t     coef_b,
  output egcd_pkg::operand_t  divisor
);
  import egcd_pkg::*;

  core_status_t core_st;
  coef_t        core_coef_a, core_coef_b;
  operand_t     core_div;
  logic         start;
  logic         ack;

  assign op_stall = core_st.busy;
  assign start    = op_valid & ~core_st.busy;
  assign ack      = core_st.done & (~res_valid | ~res_stall);

  egcd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .ack     (ack),
    .value_a (value_a),
    .value_b (value_b),
    .status  (core_st),
    .coef_a  (core_coef_a),
    .coef_b  (core_coef_b),
    .divisor (core_div)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (ack) begin
        res_valid <= 1'b1;
        coef_a    <= core_coef_a;
        coef_b    <= core_coef_b;
        divisor   <= core_div;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> op_stall)
    else $error("core not busy after operand transfer");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    core_st.done |-> core_st.busy)
    else $error("core done while idle");

  a_ack_valid: assert property (@(posedge clk) disable iff (rst)
    ack |=> res_valid)
    else $error("result lost on handoff");

  a_zero_gcd: assert property (@(posedge clk) disable iff (rst)
    ($rose(res_valid) && divisor == '0) |-> (coef_a == COEF_ONE && coef_b == COEF_ZERO))
    else $error("zero gcd without unit coefficients");

endmodule
